/* rtl/mbe_pkg.sv */
// Shared constants, state encoding and result type for the escape-time block.
package mbe_pkg;

   localparam int DEF_FRAC_BITS  = 28;
   localparam int DEF_WORD_WIDTH = 32;

   localparam int C_W       = 32;   // width of c_real / c_imag on the stream
   localparam int LIMIT_W   = 16;
   localparam int DIG_W     = 32;   // operand digit of the shared multiplier

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_NEXT,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_DONE
   } mbe_state_type;

   typedef struct packed {
      logic               escaped;
      logic [LIMIT_W-1:0] escape_step;
   } mbe_result_type;

endpackage

/* rtl/mbe_fx_mul.sv */
// Shared fixed-point multiplier: 32x32 digit products, floor shift, saturation.
module mbe_fx_mul
   import mbe_pkg::*;
#(
   parameter int WORD_WIDTH = DEF_WORD_WIDTH,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WORD_WIDTH-1:0] op_a,
   input  logic [WORD_WIDTH-1:0] op_b,
   output logic                  done,
   output logic [WORD_WIDTH-1:0] result
);

   localparam int NUM_DIG = (WORD_WIDTH + DIG_W - 1) / DIG_W;
   localparam int NPP     = NUM_DIG * NUM_DIG;
   localparam int IW      = (NPP > 1) ? $clog2(NPP) : 1;
   localparam int SW      = $clog2(2 * NUM_DIG);
   localparam int EXT_W   = NUM_DIG * DIG_W;
   localparam int ACC_W   = 2 * EXT_W;
   localparam int PW      = 2 * WORD_WIDTH;
   localparam int QW      = PW - FRAC_BITS;

   localparam logic [WORD_WIDTH-1:0] W_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] W_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [QW:0]           Q_LIM = (QW+1)'(1) << (WORD_WIDTH - 1);

   logic [WORD_WIDTH-1:0] ua_ff, ub_ff;
   logic                  neg_ff;
   logic [IW-1:0]         idx_ff;
   logic                  issue_ff, ppv_ff, fin_ff, done_ff;
   logic [2*DIG_W-1:0]    pp_ff;
   logic [SW-1:0]         sh_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [WORD_WIDTH-1:0] res_ff;

   logic [EXT_W-1:0]      ua_ext, ub_ext;
   logic [IW-1:0]         ia, ib;
   logic [DIG_W-1:0]      da, db;
   logic [SW-1:0]         sh_in;
   logic [ACC_W-1:0]      acc_in;
   logic [PW-1:0]         prod;
   logic                  rem_nz;
   logic [QW:0]           q_rnd;
   logic [WORD_WIDTH-1:0] res_in;

   function automatic logic [WORD_WIDTH-1:0] mag(input logic [WORD_WIDTH-1:0] v);
      return v[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - v) : v;
   endfunction

   // digit selection for the current partial product
   always_comb begin
      ua_ext = EXT_W'(ua_ff);
      ub_ext = EXT_W'(ub_ff);
      ia     = IW'(32'(idx_ff) % NUM_DIG);
      ib     = IW'(32'(idx_ff) / NUM_DIG);
      da     = ua_ext[32'(ia) * DIG_W +: DIG_W];
      db     = ub_ext[32'(ib) * DIG_W +: DIG_W];
      sh_in  = SW'(ia) + SW'(ib);
      acc_in = acc_ff + (ACC_W'(pp_ff) << (32'(sh_ff) * DIG_W));
   end

   // floor shift of the magnitude product, then saturate
   always_comb begin
      prod   = acc_ff[PW-1:0];
      rem_nz = |prod[FRAC_BITS-1:0];
      q_rnd  = {1'b0, prod[PW-1:FRAC_BITS]} + (QW+1)'(neg_ff & rem_nz);
      if (neg_ff) begin
         res_in = (q_rnd >= Q_LIM) ? W_MIN : (WORD_WIDTH'(0) - q_rnd[WORD_WIDTH-1:0]);
      end else begin
         res_in = (q_rnd > Q_LIM - (QW+1)'(1)) ? W_MAX : q_rnd[WORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         ppv_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         ppv_ff  <= issue_ff;
         fin_ff  <= ppv_ff && !issue_ff;
         done_ff <= fin_ff;
         if (start) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && idx_ff == IW'(NPP - 1)) begin
            issue_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff  <= mag(op_a);
         ub_ff  <= mag(op_b);
         neg_ff <= op_a[WORD_WIDTH-1] ^ op_b[WORD_WIDTH-1];
         idx_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (issue_ff) begin
            pp_ff  <= da * db;
            sh_ff  <= sh_in;
            idx_ff <= idx_ff + IW'(1);
         end
         if (ppv_ff) begin
            acc_ff <= acc_in;
         end
      end
      if (fin_ff) begin
         res_ff <= res_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* rtl/mbe_core.sv */
// Iteration sequencer: z = z*z + c with saturating adds and the escape test.
module mbe_core
   import mbe_pkg::*;
#(
   parameter int WORD_WIDTH = DEF_WORD_WIDTH,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WORD_WIDTH-1:0] c_real,
   input  logic [WORD_WIDTH-1:0] c_imag,
   input  logic [LIMIT_W-1:0]    iteration_limit,
   output logic                  idle,
   output logic                  res_valid,
   input  logic                  res_take,
   output mbe_result_type        res
);

   localparam logic [WORD_WIDTH-1:0] W_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] W_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic [WORD_WIDTH:0]   FOUR  = (WORD_WIDTH+1)'(1) << (FRAC_BITS + 2);

   mbe_state_type state_ff, state_in;

   logic [WORD_WIDTH-1:0] cr_ff, ci_ff, zr_ff, zi_ff, rr_ff, ii_ff, ri_ff, t1_ff, t2_ff;
   logic [LIMIT_W-1:0]    step_ff;
   mbe_result_type        res_ff;

   logic [WORD_WIDTH-1:0] nr_in, ni_in;
   logic [WORD_WIDTH:0]   mag_sq;
   logic                  escape, last_step;
   logic                  mul_start, mul_done;
   logic [WORD_WIDTH-1:0] mul_a, mul_b, mul_res;

   function automatic logic [WORD_WIDTH-1:0] clip(input logic [WORD_WIDTH:0] s);
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
         return s[WORD_WIDTH] ? W_MIN : W_MAX;
      end
      return s[WORD_WIDTH-1:0];
   endfunction

   function automatic logic [WORD_WIDTH-1:0] sat_add(input logic [WORD_WIDTH-1:0] a,
                                                     input logic [WORD_WIDTH-1:0] b);
      return clip({a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b});
   endfunction

   function automatic logic [WORD_WIDTH-1:0] sat_sub(input logic [WORD_WIDTH-1:0] a,
                                                     input logic [WORD_WIDTH-1:0] b);
      return clip({a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b});
   endfunction

   mbe_fx_mul #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   always_comb begin
      nr_in     = sat_add(t1_ff, cr_ff);
      ni_in     = sat_add(t2_ff, ci_ff);
      // squares are never negative, so the sum fits one extra bit
      mag_sq    = {1'b0, rr_ff} + {1'b0, ii_ff};
      escape    = mag_sq > FOUR;
      last_step = (step_ff + LIMIT_W'(1)) == iteration_limit;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (iteration_limit == '0) ? ST_DONE : ST_SUM;
            end
         end
         ST_SUM:   state_in = ST_NEXT;
         ST_NEXT:  state_in = ST_SQ_RE;
         ST_SQ_RE: if (mul_done) state_in = ST_SQ_IM;
         ST_SQ_IM: if (mul_done) state_in = ST_CROSS;
         ST_CROSS: begin
            if (mul_done) begin
               state_in = (escape || last_step) ? ST_DONE : ST_SUM;
            end
         end
         ST_DONE:  if (res_take) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_start = 1'b0;
      mul_a     = zr_ff;
      mul_b     = zi_ff;
      unique case (state_ff)
         ST_NEXT: begin
            mul_start = 1'b1;
            mul_a     = nr_in;
            mul_b     = nr_in;
         end
         ST_SQ_RE: begin
            mul_start = mul_done;
            mul_a     = zi_ff;
            mul_b     = zi_ff;
         end
         ST_SQ_IM: begin
            mul_start = mul_done;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cr_ff   <= c_real;
               ci_ff   <= c_imag;
               zr_ff   <= '0;
               zi_ff   <= '0;
               rr_ff   <= '0;
               ii_ff   <= '0;
               ri_ff   <= '0;
               step_ff <= '0;
               res_ff  <= '{escaped: 1'b0, escape_step: iteration_limit};
            end
         end
         ST_SUM: begin
            t1_ff <= sat_sub(rr_ff, ii_ff);
            t2_ff <= sat_add(ri_ff, ri_ff);
         end
         ST_NEXT: begin
            zr_ff <= nr_in;
            zi_ff <= ni_in;
         end
         ST_SQ_RE: if (mul_done) rr_ff <= mul_res;
         ST_SQ_IM: if (mul_done) ii_ff <= mul_res;
         ST_CROSS: begin
            if (mul_done) begin
               ri_ff <= mul_res;
               if (escape) begin
                  res_ff <= '{escaped: 1'b1, escape_step: step_ff};
               end else begin
                  step_ff <= step_ff + LIMIT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

/* rtl/mandelbrot_escape_time.sv */
// Mandelbrot escape-time unit: request/response stream wrapper and limit register.
//
// A request carries one point c (req_tdata: c_real in [31:0], c_imag in [63:32],
// signed Q4.28 by default). The unit iterates z = z*z + c from z = 0 and returns
// one response per request: rsp_tuser is the escaped flag, rsp_tdata the
// zero-based escape step, or iteration_limit if the point never escaped.
// csr_wr_en / csr_wr_data load iteration_limit (reset value 1000); write it only
// while no request is in flight.
// One request is worked on at a time; req_tready is high only while the
// iteration sequencer is idle. Every step runs through one shared multiplier
// that forms three products in turn (re*re, im*im, re*im), each from N*N digit
// products with N = ceil(WORD_WIDTH/32), plus the add states ST_SUM and ST_NEXT.
// With a limit of zero a point goes straight to done without iterating; the
// sequencer is ready for the next request in the same cycle its response is offered.
// The response sits in an output register; a new request is taken while it
// waits, and a finished point holds in the sequencer until that register frees.
// Reset idles the sequencer, clears the response valid and reloads the limit with 1000.
module mandelbrot_escape_time
   import mbe_pkg::*;
#(
   parameter int WORD_WIDTH = DEF_WORD_WIDTH,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [2*C_W-1:0]   req_tdata,    // c_real [31:0], c_imag [63:32]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [LIMIT_W-1:0] rsp_tdata,    // escape_step [15:0]
   output logic               rsp_tuser,    // escaped [0]
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   localparam int EXT_W = (WORD_WIDTH > C_W) ? WORD_WIDTH : C_W;

   logic [LIMIT_W-1:0]    limit_ff;
   logic                  rsp_valid_ff;
   mbe_result_type        rsp_ff;

   logic                  core_idle, core_valid, core_take, req_fire;
   logic [WORD_WIDTH-1:0] cr_in, ci_in;
   mbe_result_type        core_res;

   // sign-extend the 32-bit input and clamp it into the working word
   function automatic logic [WORD_WIDTH-1:0] clamp_in(input logic [C_W-1:0] v);
      logic signed [EXT_W-1:0] s;
      logic signed [EXT_W-1:0] hi;
      logic signed [EXT_W-1:0] lo;
      s  = EXT_W'($signed(v));
      hi = EXT_W'({1'b0, {(WORD_WIDTH-1){1'b1}}});
      lo = ~hi;
      if (s > hi) begin
         return {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end else if (s < lo) begin
         return {1'b1, {(WORD_WIDTH-1){1'b0}}};
      end
      return s[WORD_WIDTH-1:0];
   endfunction

   assign cr_in      = clamp_in(req_tdata[C_W-1:0]);
   assign ci_in      = clamp_in(req_tdata[2*C_W-1:C_W]);
   assign req_tready = core_idle;
   assign req_fire   = req_tvalid && core_idle;
   assign core_take  = core_valid && (!rsp_valid_ff || rsp_tready);

   mbe_core #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .start           (req_fire),
      .c_real          (cr_in),
      .c_imag          (ci_in),
      .iteration_limit (limit_ff),
      .idle            (core_idle),
      .res_valid       (core_valid),
      .res_take        (core_take),
      .res             (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (core_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (core_take) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.escape_step;
   assign rsp_tuser  = rsp_ff.escaped;

endmodule
